@@ rtl/core/iodw_pkg.sv @@
// Package for the immediate-or-cancel depth walk block.
// Holds field widths, item codes, status codes and the control word for the notional unit.
// No dependencies.
package iodw_pkg;

  localparam int VAL_W      = 31;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int NOTIONAL_W = 63;
  localparam int LEVEL_W    = 2 * VAL_W;

  // A quote never walks more than this many levels.
  localparam logic [4:0] WALK_CAP = 5'd16;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUOTE = 1'b1
  } func_e;

  typedef enum logic {
    KIND_FILL    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NONPOS_QTY   = 2'd1,
    ST_NONPOS_LIMIT = 2'd2,
    ST_OVERFLOW     = 2'd3
  } status_e;

  typedef struct packed {
    logic             clear;
    logic             en;
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] take;
  } mac_ctl_t;

endpackage

@@ rtl/core/iodw_if.sv @@
// Channel interfaces for the depth walk block: input words and result words.
// Each carries valid, ready and the payload fields. Depends on iodw_pkg.
interface iodw_in_if import iodw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic               side;
  logic [3:0]         level_index;
  logic signed [31:0] price;
  logic signed [31:0] quantity;
  logic [4:0]         depth;

  modport source (output valid, func, side, level_index, price, quantity, depth,
                  input ready);
  modport sink (input valid, func, side, level_index, price, quantity, depth,
                output ready);
endinterface

interface iodw_out_if import iodw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [VAL_W-1:0]      fill_price;
  logic [VAL_W-1:0]      fill_qty;
  logic [VAL_W-1:0]      filled_total;
  logic [VAL_W-1:0]      remaining;
  logic [NOTIONAL_W-1:0] notional;
  logic [VAL_W-1:0]      first_price;
  logic                  has_fill;
  logic [1:0]            status;
  logic                  last;

  modport source (output valid, kind, fill_price, fill_qty, filled_total, remaining,
                  notional, first_price, has_fill, status, last,
                  input ready);
  modport sink (input valid, kind, fill_price, fill_qty, filled_total, remaining,
                notional, first_price, has_fill, status, last,
                output ready);
endinterface

@@ rtl/core/iodw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module iodw_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/iodw_notional.sv @@
// Gross notional unit: one registered price times quantity product per fill,
// then a running sum. Depends on iodw_pkg.
module iodw_notional import iodw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mac_ctl_t              ctl_i,
  output logic [NOTIONAL_W-1:0] gross_o
);

  logic [PROD_W-1:0]     prod_q;
  logic                  prod_vld_q;
  logic [NOTIONAL_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else if (ctl_i.clear) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctl_i.en;
      if (prod_vld_q) begin
        acc_q <= acc_q + NOTIONAL_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod_q <= PROD_W'(ctl_i.price) * PROD_W'(ctl_i.take);
    end
  end

  assign gross_o = acc_q;

endmodule

@@ rtl/core/ioc_order_depth_walk_top.sv @@
// Immediate-or-cancel order walk against a two-sided price-level book. A write word
// stores one level (negative values stored as zero) and sets that side's depth, with
// no result. A quote with a non-positive quantity or limit answers with one error
// summary in the cycle after acceptance. A valid quote walks the opposite side one
// level per cycle while the output slot is free, as fast as the level memory delivers
// one entry per read; the next word is taken only once the walk has presented its
// summary. Fills leave as they are found; the summary follows. The sum of fill quantities
// is bounded by the order quantity, so the 63-bit notional never overflows.
// Depends on iodw_pkg, iodw_if, iodw_ram and iodw_notional.
module ioc_order_depth_walk_top import iodw_pkg::*; #(
  parameter int MAX_LEVELS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  iodw_in_if.sink           in_i,
  iodw_out_if.source        out_o
);

  localparam int DEPTH = 2 * MAX_LEVELS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_SUM  = 3'b100
  } state_e;

  function automatic logic [AW-1:0] slot_addr(logic book, logic [4:0] idx);
    slot_addr = book ? (AW'(MAX_LEVELS) + AW'(idx)) : AW'(idx);
  endfunction

  state_e state_q, state_d;

  logic [4:0]       depth_q [2];
  logic [4:0]       depth_d [2];
  logic             book_q, book_d;
  logic             buy_q, buy_d;
  logic [4:0]       i_q, i_d;
  logic [4:0]       n_q, n_d;
  logic [VAL_W-1:0] limit_q, limit_d;
  logic [VAL_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] filled_q, filled_d;
  logic [VAL_W-1:0] first_q, first_d;
  logic             has_q, has_d;

  logic                  out_vld_q, out_vld_d;
  kind_e                 out_kind_q, out_kind_d;
  logic [VAL_W-1:0]      out_fprice_q, out_fprice_d;
  logic [VAL_W-1:0]      out_fqty_q, out_fqty_d;
  logic [VAL_W-1:0]      out_filled_q, out_filled_d;
  logic [VAL_W-1:0]      out_rem_q, out_rem_d;
  logic [NOTIONAL_W-1:0] out_gross_q, out_gross_d;
  logic [VAL_W-1:0]      out_first_q, out_first_d;
  logic                  out_has_q, out_has_d;
  status_e               out_status_q, out_status_d;

  logic                  in_fire, slot_free;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [LEVEL_W-1:0]    ram_wdata, ram_rdata;
  logic [VAL_W-1:0]      lp, lq, take;
  logic                  mkt, walk_end, walk_fire;
  logic [4:0]            dep_sat, dsel;
  mac_ctl_t              mac_ctl;
  logic [NOTIONAL_W-1:0] gross;

  assign slot_free = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && slot_free;
  assign in_fire = in_i.valid && in_i.ready;

  assign lp   = ram_rdata[LEVEL_W-1:VAL_W];
  assign lq   = ram_rdata[VAL_W-1:0];
  assign take = (rem_q < lq) ? rem_q : lq;
  assign mkt  = buy_q ? (lp <= limit_q) : (lp >= limit_q);
  assign walk_end  = (i_q == n_q) || (rem_q == '0) || !mkt;
  assign walk_fire = (state_q == S_WALK) && !walk_end && slot_free;

  assign dep_sat = (32'(in_i.depth) > MAX_LEVELS) ? 5'(MAX_LEVELS) : in_i.depth;
  assign dsel    = depth_q[~in_i.side];

  // Level writes; a level index beyond the table stores nothing.
  assign ram_we    = in_fire && (in_i.func == FUNC_WRITE) && (32'(in_i.level_index) < MAX_LEVELS);
  assign ram_waddr = slot_addr(in_i.side, {1'b0, in_i.level_index});
  assign ram_wdata = {(in_i.price[31] ? '0 : in_i.price[VAL_W-1:0]),
                      (in_i.quantity[31] ? '0 : in_i.quantity[VAL_W-1:0])};
  // The read address follows the next level index, so a stalled walk rereads its level.
  assign ram_raddr = slot_addr(book_d, i_d);

  always_comb begin
    state_d    = state_q;
    depth_d    = depth_q;
    book_d     = book_q;
    buy_d      = buy_q;
    i_d        = i_q;
    n_d        = n_q;
    limit_d    = limit_q;
    rem_d      = rem_q;
    filled_d   = filled_q;
    first_d    = first_q;
    has_d      = has_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_kind_d   = out_kind_q;
    out_fprice_d = out_fprice_q;
    out_fqty_d   = out_fqty_q;
    out_filled_d = out_filled_q;
    out_rem_d    = out_rem_q;
    out_gross_d  = out_gross_q;
    out_first_d  = out_first_q;
    out_has_d    = out_has_q;
    out_status_d = out_status_q;
    mac_ctl.clear = 1'b0;
    mac_ctl.en    = walk_fire;
    mac_ctl.price = lp;
    mac_ctl.take  = take;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.func == FUNC_WRITE) begin
            depth_d[in_i.side] = dep_sat;
          end else if (in_i.quantity[31] || (in_i.quantity == '0) ||
                       in_i.price[31] || (in_i.price == '0)) begin
            out_vld_d    = 1'b1;
            out_kind_d   = KIND_SUMMARY;
            out_fprice_d = '0;
            out_fqty_d   = '0;
            out_filled_d = '0;
            out_rem_d    = '0;
            out_gross_d  = '0;
            out_first_d  = '0;
            out_has_d    = 1'b0;
            out_status_d = (in_i.quantity[31] || (in_i.quantity == '0)) ? ST_NONPOS_QTY
                                                                        : ST_NONPOS_LIMIT;
          end else begin
            book_d   = ~in_i.side;
            buy_d    = !in_i.side;
            i_d      = '0;
            n_d      = (dsel > WALK_CAP) ? WALK_CAP : dsel;
            limit_d  = in_i.price[VAL_W-1:0];
            rem_d    = in_i.quantity[VAL_W-1:0];
            filled_d = '0;
            first_d  = '0;
            has_d    = 1'b0;
            mac_ctl.clear = 1'b1;
            state_d  = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_d = S_SUM;
        end else if (walk_fire) begin
          out_vld_d    = 1'b1;
          out_kind_d   = KIND_FILL;
          out_fprice_d = lp;
          out_fqty_d   = take;
          out_filled_d = '0;
          out_rem_d    = '0;
          out_gross_d  = '0;
          out_first_d  = '0;
          out_has_d    = 1'b0;
          out_status_d = ST_OK;
          rem_d    = rem_q - take;
          filled_d = filled_q + take;
          i_d      = i_q + 5'd1;
          if (!has_q) begin
            first_d = lp;
            has_d   = 1'b1;
          end
        end
      end
      S_SUM: begin
        // The last product has reached the accumulator by the time this state is entered.
        if (slot_free) begin
          out_vld_d    = 1'b1;
          out_kind_d   = KIND_SUMMARY;
          out_fprice_d = '0;
          out_fqty_d   = '0;
          out_filled_d = filled_q;
          out_rem_d    = rem_q;
          out_gross_d  = gross;
          out_first_d  = first_q;
          out_has_d    = has_q;
          out_status_d = ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      depth_q[0] <= '0;
      depth_q[1] <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      depth_q   <= depth_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    book_q       <= book_d;
    buy_q        <= buy_d;
    i_q          <= i_d;
    n_q          <= n_d;
    limit_q      <= limit_d;
    rem_q        <= rem_d;
    filled_q     <= filled_d;
    first_q      <= first_d;
    has_q        <= has_d;
    out_kind_q   <= out_kind_d;
    out_fprice_q <= out_fprice_d;
    out_fqty_q   <= out_fqty_d;
    out_filled_q <= out_filled_d;
    out_rem_q    <= out_rem_d;
    out_gross_q  <= out_gross_d;
    out_first_q  <= out_first_d;
    out_has_q    <= out_has_d;
    out_status_q <= out_status_d;
  end

  iodw_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (DEPTH)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  iodw_notional u_notional (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .gross_o (gross)
  );

  assign out_o.valid        = out_vld_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.fill_price   = out_fprice_q;
  assign out_o.fill_qty     = out_fqty_q;
  assign out_o.filled_total = out_filled_q;
  assign out_o.remaining    = out_rem_q;
  assign out_o.notional     = out_gross_q;
  assign out_o.first_price  = out_first_q;
  assign out_o.has_fill     = out_has_q;
  assign out_o.status       = out_status_q;
  assign out_o.last         = (out_kind_q == KIND_SUMMARY);

  // The walk never passes the level count it latched.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (i_q <= n_q))
    else $error("walk index beyond level count");

  // Each fill moves quantity from remaining to filled without changing the total.
  a_qty_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) && $past(state_q == S_WALK) |->
      (({1'b0, filled_q} + {1'b0, rem_q}) == $past({1'b0, filled_q} + {1'b0, rem_q})))
    else $error("filled plus remaining changed during walk");

  // A fill taken in the walk appears as a fill word in the next cycle.
  a_fill_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_fire |=> (out_vld_q && (out_kind_q == KIND_FILL)))
    else $error("fill not presented");

  // Leaving the summary state always presents a final word.
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) && slot_free |=>
      ((state_q == S_IDLE) && out_vld_q && (out_kind_q == KIND_SUMMARY)))
    else $error("summary not presented");

endmodule
